// ===== src/skset_pkg.sv =====
// ----------------------------------------------------------------------------
// skset_pkg
// Shared widths, command codes and the cell control bundle for the sorted
// key set.
// ----------------------------------------------------------------------------
package skset_pkg;

   // field widths
   localparam int KEY_W = 32;
   localparam int CMD_W = 2;
   localparam int OCC_W = 7;

   // default number of key slots
   localparam int DEFAULT_CAPACITY = 64;

   // largest key value, reserved as the end marker and never stored
   localparam logic signed [KEY_W-1:0] END_MARKER = 32'sh7FFF_FFFF;

   // request command codes
   localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd2;

   // broadcast to every cell in the commit cycle
   typedef struct packed {
      logic ins;
      logic del;
   } skset_apply_type;

endpackage

// ===== src/skset_cell.sv =====
// ----------------------------------------------------------------------------
// skset_cell
// One slot of the ordered key row: compares its key against the request key
// and shifts toward its neighbor on an insert or a delete.
// ----------------------------------------------------------------------------
module skset_cell import skset_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   parameter int INDEX    = 0
) (
   input  logic                              clock,
   input  logic                              compare_en,
   input  skset_apply_type                   apply,
   input  logic signed [KEY_W-1:0]           op_key,
   input  logic [$clog2(CAPACITY+1)-1:0]     count,
   input  logic signed [KEY_W-1:0]           left_key,
   input  logic                              left_lt,
   input  logic signed [KEY_W-1:0]           right_key,
   output logic signed [KEY_W-1:0]           key_out,
   output logic                              lt_out,
   output logic                              eq_out
);

   localparam int CNT_W = $clog2(CAPACITY+1);
   localparam logic [CNT_W-1:0] SLOT = CNT_W'(INDEX);

   logic signed [KEY_W-1:0] key_ff, key_in;
   logic                    lt_ff, lt_in;
   logic                    eq_ff, eq_in;
   logic                    occupied;

   // slot holds a key when it lies below the fill count
   assign occupied = SLOT < count;

   // compare stage results
   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (compare_en) begin
         lt_in = occupied && (key_ff < op_key);
         eq_in = occupied && (key_ff == op_key);
      end
   end

   // shift: slots at or past the insert point take from the left,
   // slots at or past the delete point take from the right
   always_comb begin
      key_in = key_ff;
      priority if (apply.ins && !lt_ff) begin
         key_in = left_lt ? op_key : left_key;
      end else if (apply.del && !lt_ff) begin
         key_in = right_key;
      end else begin
         key_in = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key_out = key_ff;
   assign lt_out  = lt_ff;
   assign eq_out  = eq_ff;

endmodule

// ===== src/sorted_key_set_core.sv =====
// ----------------------------------------------------------------------------
// sorted_key_set_core
// Set of distinct signed keys kept in ascending order in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall) carries a command and a key:
//   add, remove or contains. Command code 3 is ignored and answered ok 0.
//   rsp channel (rsp_valid / rsp_stall) returns one response per request:
//   ok, full_res (add refused because the set holds CAPACITY keys) and the
//   key count after the request, masked to 7 bits.
//   Sequence: a request is taken into the command and key registers; the
//   compare state then compares the key against every cell at once, and the
//   apply state commits the shift and registers the response, which is valid
//   from that register; neither step depends on how many keys are held.
//   A request is not taken while the last one is still comparing.
//   The next request is taken at the commit edge.
//   A stalled response holds; the commit of the following request waits
//   until the response register is free, and req_stall stays high meanwhile.
//   Reset empties the set at once; the block accepts requests in the cycle
//   after reset is released.
// ----------------------------------------------------------------------------
module sorted_key_set_core import skset_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CMD_W-1:0]        req_command,
   input  logic signed [KEY_W-1:0] req_key,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_ok,
   output logic                    rsp_full_res,
   output logic [OCC_W-1:0]        rsp_occupancy
);

   localparam int CNT_W = $clog2(CAPACITY+1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_COMPARE = 3'b010,
      ST_APPLY   = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic                    rsp_full_ff, rsp_full_in;
   logic [OCC_W-1:0]        rsp_occ_ff, rsp_occ_in;

   logic                    req_take;
   logic                    commit;
   logic                    compare_en;
   logic                    present;
   logic                    is_marker;
   logic                    set_full;
   logic                    ok_val;
   logic                    full_val;
   skset_apply_type         apply;
   logic [CNT_W+OCC_W-1:0]  occ_wide;

   logic signed [KEY_W-1:0] key_vec [CAPACITY];
   logic [CAPACITY-1:0]     lt_vec;
   logic [CAPACITY-1:0]     eq_vec;

   // handshake and phase control
   assign commit     = (state_ff == ST_APPLY) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = !((state_ff == ST_IDLE) || commit);
   assign req_take   = req_valid && !req_stall;
   assign compare_en = (state_ff == ST_COMPARE);

   // row of compare-and-shift cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_W-1:0] left_key;
      logic signed [KEY_W-1:0] right_key;
      logic                    left_lt;

      if (i == 0) begin : g_first
         assign left_key = key_ff;
         assign left_lt  = 1'b1;
      end else begin : g_mid
         assign left_key = key_vec[i-1];
         assign left_lt  = lt_vec[i-1];
      end

      if (i == CAPACITY-1) begin : g_last
         assign right_key = key_vec[i];
      end else begin : g_inner
         assign right_key = key_vec[i+1];
      end

      skset_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock      (clock),
         .compare_en (compare_en),
         .apply      (apply),
         .op_key     (key_ff),
         .count      (count_ff),
         .left_key   (left_key),
         .left_lt    (left_lt),
         .right_key  (right_key),
         .key_out    (key_vec[i]),
         .lt_out     (lt_vec[i]),
         .eq_out     (eq_vec[i])
      );
   end

   // request decision from the registered compare results
   assign present   = |eq_vec;
   assign is_marker = (key_ff == END_MARKER);
   assign set_full  = (count_ff == FULL_COUNT);

   always_comb begin
      apply    = '0;
      ok_val   = 1'b0;
      full_val = 1'b0;
      unique case (cmd_ff)
         CMD_ADD: begin
            if (!is_marker && !present) begin
               if (set_full) begin
                  full_val = 1'b1;
               end else begin
                  ok_val    = 1'b1;
                  apply.ins = commit;
               end
            end
         end
         CMD_REMOVE: begin
            if (!is_marker && present) begin
               ok_val    = 1'b1;
               apply.del = commit;
            end
         end
         CMD_CONTAINS: begin
            ok_val = is_marker || present;
         end
         default: begin
            ok_val = 1'b0;
         end
      endcase
   end

   // fill count
   always_comb begin
      count_in = count_ff;
      priority if (apply.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (apply.del) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   assign occ_wide = {{OCC_W{1'b0}}, count_in};

   // phase sequencing and request capture
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      key_in   = key_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (commit) state_in = req_take ? ST_COMPARE : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (req_take) begin
         cmd_in = req_command;
         key_in = req_key;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ok_in    = rsp_ok_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_occ_in   = rsp_occ_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = ok_val;
         rsp_full_in  = full_val;
         rsp_occ_in   = occ_wide[OCC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_full_ff <= rsp_full_in;
      rsp_occ_ff  <= rsp_occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_full_res  = rsp_full_ff;
   assign rsp_occupancy = rsp_occ_ff;

`ifndef NO_ASSERTIONS
   // fill count never passes the number of cells
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("key count exceeds capacity");

   // keys are distinct, so at most one cell matches
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> $onehot0(eq_vec))
      else $error("more than one cell matches the key");

   // count moves only at a commit
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> $past(commit))
      else $error("key count changed outside a commit");

   // a new response appears only from a commit
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(commit))
      else $error("response raised without a commit");
`endif

endmodule
